// ===== hw/rtl/bdlp_pkg.sv =====
package bdlp_pkg;

   localparam int NUM_BUTTONS_DEF = 6;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam int PIN_W       = 6;
   localparam int MS_W        = 8;
   localparam int BTN_W       = 3;
   localparam int KIND_W      = 2;
   localparam int CFG_MS_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_PRESSED_LEVEL = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_MS   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_PRESS_MS = CSR_INDEX_W'(2);

   localparam logic                RST_PRESSED_LEVEL = 1'b0;
   localparam logic [CFG_MS_W-1:0] RST_DEBOUNCE_MS   = CFG_MS_W'(50);
   localparam logic [CFG_MS_W-1:0] RST_LONG_PRESS_MS = CFG_MS_W'(1000);

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE  = 2'd0,
      KIND_PRESS = 2'd1,
      KIND_LONG  = 2'd2
   } bdlp_kind_type;

   typedef struct packed {
      logic                pressed_level;
      logic [CFG_MS_W-1:0] debounce_ms;
      logic [CFG_MS_W-1:0] long_press_ms;
   } bdlp_cfg_type;

   typedef struct packed {
      logic press;
      logic long_press;
   } bdlp_event_type;

endpackage

// ===== hw/rtl/bdlp_csr.sv =====
module bdlp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [bdlp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]    csr_data,
   output bdlp_pkg::bdlp_cfg_type             cfg
);
   import bdlp_pkg::*;

   bdlp_cfg_type cfg_ff;
   bdlp_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_PRESSED_LEVEL: cfg_in.pressed_level = csr_data[0];
            REG_DEBOUNCE_MS:   cfg_in.debounce_ms   = csr_data[CFG_MS_W-1:0];
            REG_LONG_PRESS_MS: cfg_in.long_press_ms = csr_data[CFG_MS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_level <= RST_PRESSED_LEVEL;
         cfg_ff.debounce_ms   <= RST_DEBOUNCE_MS;
         cfg_ff.long_press_ms <= RST_LONG_PRESS_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/bdlp_button.sv =====
module bdlp_button #(
   parameter int COUNT_WIDTH = bdlp_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          pin,
   input  logic [bdlp_pkg::MS_W-1:0]     ms,
   input  bdlp_pkg::bdlp_cfg_type        cfg,
   output bdlp_pkg::bdlp_event_type      event_out
);
   import bdlp_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > CFG_MS_W) ? COUNT_WIDTH : CFG_MS_W;

   logic                   last_raw_ff, last_raw_in;
   logic                   stable_ff, stable_in;
   logic                   long_sent_ff, long_sent_in;
   logic [COUNT_WIDTH-1:0] quiet_ff, quiet_in;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;

   logic                   raw;
   logic [COUNT_WIDTH:0]   hold_sum;
   logic [COUNT_WIDTH:0]   quiet_sum;
   logic [COUNT_WIDTH-1:0] hold_sat;
   logic [COUNT_WIDTH-1:0] quiet_sat;
   bdlp_event_type         ev;

   assign raw       = (pin == cfg.pressed_level);
   assign hold_sum  = {1'b0, hold_ff} + (COUNT_WIDTH+1)'(ms);
   assign quiet_sum = {1'b0, quiet_ff} + (COUNT_WIDTH+1)'(ms);
   // counters stick at all ones instead of wrapping
   assign hold_sat  = hold_sum[COUNT_WIDTH] ? '1 : hold_sum[COUNT_WIDTH-1:0];
   assign quiet_sat = quiet_sum[COUNT_WIDTH] ? '1 : quiet_sum[COUNT_WIDTH-1:0];

   always_comb begin
      last_raw_in  = raw;
      quiet_in     = (raw != last_raw_ff) ? '0 : quiet_sat;
      hold_in      = hold_sat;
      stable_in    = stable_ff;
      long_sent_in = long_sent_ff;
      ev           = '0;
      if (CMP_W'(quiet_in) >= CMP_W'(cfg.debounce_ms)) begin
         if (raw != stable_ff) begin
            stable_in = raw;
            if (raw) begin
               hold_in      = '0;
               long_sent_in = 1'b0;
               ev.press     = 1'b1;
            end
         end else if (raw && !long_sent_ff &&
                      CMP_W'(hold_sat) >= CMP_W'(cfg.long_press_ms)) begin
            long_sent_in  = 1'b1;
            ev.long_press = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff  <= 1'b0;
         stable_ff    <= 1'b0;
         long_sent_ff <= 1'b0;
         quiet_ff     <= '0;
         hold_ff      <= '0;
      end else if (step) begin
         last_raw_ff  <= last_raw_in;
         stable_ff    <= stable_in;
         long_sent_ff <= long_sent_in;
         quiet_ff     <= quiet_in;
         hold_ff      <= hold_in;
      end
   end

   assign event_out = ev;

   a_press_sets_stable: assert property (@(posedge clock) disable iff (reset)
      (step && ev.press) |=> (stable_ff && !long_sent_ff && hold_ff == '0))
      else $error("press did not leave the button stably pressed");

   a_long_once: assert property (@(posedge clock) disable iff (reset)
      (step && ev.long_press) |=> (long_sent_ff && stable_ff))
      else $error("long press not recorded");

   a_long_needs_stable: assert property (@(posedge clock) disable iff (reset)
      ev.long_press |-> (stable_ff && !long_sent_ff && !ev.press))
      else $error("long press without a held stable press");

endmodule

// ===== hw/rtl/button_debounce_long_press_top.sv =====
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_pin_levels, req_ms_elapsed
// rsp       out        rsp_valid / rsp_stall     rsp_event_button, rsp_event_kind
// csr       in         csr_write_en              csr_index, csr_data
//
// one request per cycle sustained while the result is not stalled; an accepted request passes through
// request register, then per-button counters and the event pick, then result register
// reset is synchronous and clears all button state and restores register defaults
// a stalled result holds; one more request is taken into the request register meanwhile
module button_debounce_long_press_top #(
   parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF,
   parameter int COUNT_WIDTH = bdlp_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdlp_pkg::PIN_W-1:0]         req_pin_levels,
   input  logic [bdlp_pkg::MS_W-1:0]          req_ms_elapsed,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdlp_pkg::BTN_W-1:0]         rsp_event_button,
   output logic [bdlp_pkg::KIND_W-1:0]        rsp_event_kind,
   input  logic                               csr_write_en,
   input  logic [bdlp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bdlp_pkg::*;

   bdlp_cfg_type   cfg;
   bdlp_event_type events [NUM_BUTTONS];

   logic             s1_valid_ff, s1_valid_in;
   logic [PIN_W-1:0] s1_pins_ff;
   logic [MS_W-1:0]  s1_ms_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BTN_W-1:0]   rsp_button_ff, sel_button;
   bdlp_kind_type      rsp_kind_ff, sel_kind;

   logic out_ready;
   logic step;
   logic req_take;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   bdlp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
      logic pin;
      if (g < PIN_W) begin : g_pin
         assign pin = s1_pins_ff[g];
      end else begin : g_nopin
         assign pin = 1'b0;
      end
      bdlp_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_button (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .pin       (pin),
         .ms        (s1_ms_ff),
         .cfg       (cfg),
         .event_out (events[g])
      );
   end

   // highest index with an event wins
   always_comb begin
      sel_button = '0;
      sel_kind   = KIND_NONE;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (events[i].press) begin
            sel_button = BTN_W'(i + 1);
            sel_kind   = KIND_PRESS;
         end else if (events[i].long_press) begin
            sel_button = BTN_W'(i + 1);
            sel_kind   = KIND_LONG;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pins_ff <= req_pin_levels;
         s1_ms_ff   <= req_ms_elapsed;
      end
      if (step) begin
         rsp_button_ff <= sel_button;
         rsp_kind_ff   <= sel_kind;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_button = rsp_button_ff;
   assign rsp_event_kind   = rsp_kind_ff;

   a_none_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == KIND_NONE) == (rsp_button_ff == '0)))
      else $error("event button and kind disagree");

   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed request lost before the result register");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_pins_ff)
                                       && $stable(s1_ms_ff)))
      else $error("waiting request dropped or changed");

endmodule
